// ----- src/lsgs_pkg.sv -----
// Shared widths, register indexes and types for the Laplacian stencil grid step unit.
package lsgs_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int COLS_W       = 11;
	localparam int ROWS_W       = 16;
	localparam int ROWCNT_W     = 17;
	localparam int COEF_W       = 16;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int MAX_COLS_DEF = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y    = CFG_IDX_W'(3);

	localparam logic [COLS_W-1:0] GRID_COLS_RST = COLS_W'(16);
	localparam logic [ROWS_W-1:0] GRID_ROWS_RST = ROWS_W'(16);
	localparam logic [COEF_W-1:0] COEF_RST      = '0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t two_back;
		sample_t one_back;
	} line_word_t;

	typedef struct packed {
		sample_t left;
		sample_t center;
		sample_t right;
		sample_t up;
		sample_t down;
	} window_t;

	typedef struct packed {
		logic [COLS_W-1:0] grid_cols;
		logic [ROWS_W-1:0] grid_rows;
		logic [COEF_W-1:0] coef_x;
		logic [COEF_W-1:0] coef_y;
	} cfg_t;

	typedef struct packed {
		logic right_ok;
		logic center_ok;
	} rd_ok_t;

endpackage

// ----- src/lsgs_sample_if.sv -----
// Input sample channel.
interface lsgs_sample_if;
	logic                 valid;
	logic                 ready;
	lsgs_pkg::sample_t    sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

// ----- src/lsgs_result_if.sv -----
// Result channel: updated interior point with its coordinates.
interface lsgs_result_if;
	logic                            valid;
	logic                            ready;
	lsgs_pkg::sample_t               new_value;
	logic [lsgs_pkg::COLS_W-1:0]     col;
	logic [lsgs_pkg::ROWS_W-1:0]     row;
	logic                            last;

	modport source(output valid, output new_value, output col, output row, output last,
		input ready);
	modport sink(input valid, input new_value, input col, input row, input last,
		output ready);
endinterface

// ----- src/lsgs_cfg_if.sv -----
// Register write channel.
interface lsgs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lsgs_pkg::CFG_IDX_W-1:0]    index;
	logic [lsgs_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- src/lsgs_line_mem.sv -----
// Line store memory: two previous rows per column, two registered reads, one write, fill count.
module lsgs_line_mem #(
	parameter int DEPTH = lsgs_pkg::MAX_COLS_DEF + 2,
	localparam int AW = $clog2(DEPTH),
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        addr_a,
	input  logic [AW-1:0]        addr_b,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  lsgs_pkg::line_word_t wdata,
	output lsgs_pkg::line_word_t rda,
	output lsgs_pkg::line_word_t rdb,
	output lsgs_pkg::rd_ok_t     ok
);

	lsgs_pkg::line_word_t mem_q [DEPTH];
	lsgs_pkg::line_word_t rda_q;
	lsgs_pkg::line_word_t rdb_q;
	lsgs_pkg::rd_ok_t     ok_q;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        wnext;

	assign wnext = FW'(waddr) + FW'(1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rda_q <= mem_q[addr_a];
			rdb_q <= mem_q[addr_b];
		end
	end

	// columns are written in ascending order, so written entries form a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ok_q   <= '0;
		end else begin
			if (we && (wnext > fill_q)) begin
				fill_q <= wnext;
			end
			if (rd_en) begin
				ok_q.right_ok  <= FW'(addr_a) < fill_q;
				ok_q.center_ok <= FW'(addr_b) < fill_q;
			end
		end
	end

	assign rda = rda_q;
	assign rdb = rdb_q;
	assign ok  = ok_q;

endmodule

// ----- src/lsgs_cfg_regs.sv -----
// Configuration registers: grid size and diffusion coefficients.
module lsgs_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	lsgs_cfg_if.sink       cfg,
	output lsgs_pkg::cfg_t regs
);

	lsgs_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.grid_cols <= lsgs_pkg::GRID_COLS_RST;
			regs_q.grid_rows <= lsgs_pkg::GRID_ROWS_RST;
			regs_q.coef_x    <= lsgs_pkg::COEF_RST;
			regs_q.coef_y    <= lsgs_pkg::COEF_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lsgs_pkg::REG_GRID_COLS: regs_q.grid_cols <= cfg.data[lsgs_pkg::COLS_W-1:0];
				lsgs_pkg::REG_GRID_ROWS: regs_q.grid_rows <= cfg.data[lsgs_pkg::ROWS_W-1:0];
				lsgs_pkg::REG_COEF_X:    regs_q.coef_x    <= cfg.data[lsgs_pkg::COEF_W-1:0];
				lsgs_pkg::REG_COEF_Y:    regs_q.coef_y    <= cfg.data[lsgs_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- src/lsgs_stencil.sv -----
// Five-point stencil update with round-half-up and saturation to Q16.16.
module lsgs_stencil (
	input  lsgs_pkg::window_t                win,
	input  logic [lsgs_pkg::COEF_W-1:0]     coef_x,
	input  logic [lsgs_pkg::COEF_W-1:0]     coef_y,
	output lsgs_pkg::sample_t               new_value
);

	localparam int SW     = lsgs_pkg::SAMPLE_W;
	localparam int FRAC_W = lsgs_pkg::COEF_W;
	localparam int LAP_W  = SW + 2;
	localparam int PROD_W = LAP_W + FRAC_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam int TOP_W  = ACC_W - FRAC_W - SW + 1;

	logic signed [LAP_W-1:0]  left_x, right_x, center_x, up_x, down_x;
	logic signed [LAP_W-1:0]  lap_x, lap_y;
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [ACC_W-1:0]  center_sc, acc;
	logic [TOP_W-1:0]         top_bits;
	logic                     in_range;

	always_comb begin
		left_x   = $signed({{(LAP_W-SW){win.left[SW-1]}}, win.left});
		right_x  = $signed({{(LAP_W-SW){win.right[SW-1]}}, win.right});
		center_x = $signed({{(LAP_W-SW){win.center[SW-1]}}, win.center});
		up_x     = $signed({{(LAP_W-SW){win.up[SW-1]}}, win.up});
		down_x   = $signed({{(LAP_W-SW){win.down[SW-1]}}, win.down});

		lap_x = left_x + right_x - (center_x <<< 1);
		lap_y = up_x + down_x - (center_x <<< 1);

		prod_x = lap_x * $signed({1'b0, coef_x});
		prod_y = lap_y * $signed({1'b0, coef_y});

		center_sc = $signed({{(ACC_W-SW-FRAC_W){win.center[SW-1]}}, win.center,
			{FRAC_W{1'b0}}});
		acc = center_sc + ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(2 ** (FRAC_W - 1));

		top_bits = acc[ACC_W-1:FRAC_W+SW-1];
		in_range = (&top_bits) || !(|top_bits);

		if (in_range) begin
			new_value = acc[FRAC_W+SW-1:FRAC_W];
		end else if (acc[ACC_W-1]) begin
			new_value = {1'b1, {(SW-1){1'b0}}};
		end else begin
			new_value = {1'b0, {(SW-1){1'b1}}};
		end
	end

endmodule

// ----- src/laplacian_stencil_grid_step_unit.sv -----
// Top level of the Laplacian stencil grid step unit: scan counters, line stores, stage and output.
//
//  channel   dir  payload                     accepted when
//  samples   in   sample                      samples.valid & samples.ready
//  results   out  new_value, col, row, last   results.valid & results.ready
//  cfg       in   index, data                 cfg.valid & cfg.ready (ready tied high)
//
// One word per cycle sustained while results are not stalled; a result passes through the stage
// register and then the output register. Both line-store reads for a column come from one
// dual-read memory. Reset clears counters, valid flags and the memory fill count; no clearing
// pass, unwritten columns read as zero. A stalled result holds the output register; words are
// still taken into the stage register until it holds a result, then samples.ready drops.
module laplacian_stencil_grid_step_unit #(
	parameter int MAX_COLS = lsgs_pkg::MAX_COLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	lsgs_sample_if.sink    samples,
	lsgs_result_if.source  results,
	lsgs_cfg_if.sink       cfg
);

	localparam int DEPTH = MAX_COLS + 2;
	localparam int CW    = $clog2(DEPTH);
	localparam int CMW   = ((CW > lsgs_pkg::COLS_W) ? CW : lsgs_pkg::COLS_W) + 1;
	localparam int RW    = lsgs_pkg::ROWCNT_W;

	lsgs_pkg::cfg_t       cfg_vals;
	lsgs_pkg::line_word_t rda, rdb, right_w, center_w, wdata;
	lsgs_pkg::rd_ok_t     rd_ok;
	lsgs_pkg::window_t    win;
	lsgs_pkg::sample_t    stencil_val;

	logic [CW-1:0]        x_q, prev_x_q, addr_a, waddr;
	logic [RW-1:0]        y_q;
	logic                 prev_end_q;
	lsgs_pkg::sample_t    held_q;

	logic [CMW-1:0]                  cols_raw, cols_eff, x_ext;
	logic [lsgs_pkg::ROWS_W-1:0]     rows_eff;
	logic                            row_end, last_row, emit, pt_last;
	logic                            en, s1_free, acc, we;

	logic                            vld_s1;
	lsgs_pkg::sample_t               left_s1, down_s1;
	logic [lsgs_pkg::COLS_W-1:0]     col_s1;
	logic [lsgs_pkg::ROWS_W-1:0]     row_s1;
	logic                            last_s1;

	logic                            out_vld_q;
	lsgs_pkg::sample_t               new_value_q;
	logic [lsgs_pkg::COLS_W-1:0]     col_q;
	logic [lsgs_pkg::ROWS_W-1:0]     row_q;
	logic                            last_q;

	lsgs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_vals)
	);

	// scan position decode
	always_comb begin
		cols_raw = CMW'(cfg_vals.grid_cols);
		if (cols_raw == '0) begin
			cols_eff = CMW'(1);
		end else if (cols_raw > CMW'(MAX_COLS)) begin
			cols_eff = CMW'(MAX_COLS);
		end else begin
			cols_eff = cols_raw;
		end
		rows_eff = (cfg_vals.grid_rows == '0) ? lsgs_pkg::ROWS_W'(1) : cfg_vals.grid_rows;
		x_ext    = CMW'(x_q);
		row_end  = x_ext >= (cols_eff + CMW'(1));
		last_row = y_q >= ({1'b0, rows_eff} + RW'(1));
		emit     = (y_q >= RW'(2)) && (x_q != '0) && (x_ext <= cols_eff);
		pt_last  = (x_ext == cols_eff) && last_row;
	end

	assign en            = !out_vld_q || results.ready;
	assign s1_free       = !vld_s1 || en;
	assign samples.ready = s1_free;
	assign acc           = samples.valid && s1_free;

	// read data from the last accepted word; unwritten columns read as zero
	assign right_w  = rd_ok.right_ok ? rda : '0;
	assign center_w = rd_ok.center_ok ? rdb : '0;

	// column x-1 retires on each word; the right border column retires on the next row start
	assign addr_a         = (x_q == CW'(DEPTH - 1)) ? x_q : (x_q + CW'(1));
	assign we             = acc && ((x_q != '0) || prev_end_q);
	assign waddr          = (x_q != '0) ? (x_q - CW'(1)) : prev_x_q;
	assign wdata.two_back = center_w.one_back;
	assign wdata.one_back = held_q;

	lsgs_line_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (acc),
		.addr_a (addr_a),
		.addr_b (x_q),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.rda    (rda),
		.rdb    (rdb),
		.ok     (rd_ok)
	);

	assign win.left   = left_s1;
	assign win.center = center_w.one_back;
	assign win.right  = right_w.one_back;
	assign win.up     = center_w.two_back;
	assign win.down   = down_s1;

	lsgs_stencil u_stencil (
		.win       (win),
		.coef_x    (cfg_vals.coef_x),
		.coef_y    (cfg_vals.coef_y),
		.new_value (stencil_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q        <= '0;
			y_q        <= '0;
			prev_end_q <= 1'b0;
			vld_s1     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (acc) begin
				prev_end_q <= row_end;
				vld_s1     <= emit;
				if (row_end) begin
					x_q <= '0;
					y_q <= last_row ? '0 : (y_q + RW'(1));
				end else begin
					x_q <= x_q + CW'(1);
				end
			end else if (en) begin
				vld_s1 <= 1'b0;
			end
			if (en) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			held_q   <= samples.sample;
			prev_x_q <= x_q;
			left_s1  <= center_w.one_back;
			down_s1  <= samples.sample;
			col_s1   <= lsgs_pkg::COLS_W'(x_q);
			row_s1   <= lsgs_pkg::ROWS_W'(y_q - RW'(1));
			last_s1  <= pt_last;
		end
		if (en && vld_s1) begin
			new_value_q <= stencil_val;
			col_q       <= col_s1;
			row_q       <= row_s1;
			last_q      <= last_s1;
		end
	end

	assign results.valid     = out_vld_q;
	assign results.new_value = new_value_q;
	assign results.col       = col_q;
	assign results.row       = row_q;
	assign results.last      = last_q;

endmodule
